/* rtl/qn_pkg.sv */
`timescale 1ns / 1ps

package qn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NCOMP      = 4;
    localparam int CW         = 32;
    localparam int SQW        = 2 * CW;
    localparam int SUMW       = SQW + 2;
    localparam int RTW        = CW + 1;
    localparam int REMW       = RTW + 3;
    localparam int SQ_STAGES  = SUMW / 2;
    localparam int QW         = FRAC_BITS + 1;
    localparam int DRW        = RTW + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int MINW       = 16;
    localparam int PAW        = 3;
    localparam int DW         = 32;

    localparam logic [0:0] REG_MIN_MAGNITUDE = 1'b0;

    typedef logic [NCOMP-1:0][CW-1:0] t_vec;

    typedef struct packed {
        logic signed [CW-1:0] comp_w;
        logic signed [CW-1:0] comp_x;
        logic signed [CW-1:0] comp_y;
        logic signed [CW-1:0] comp_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] unit_w;
        logic signed [CW-1:0] unit_x;
        logic signed [CW-1:0] unit_y;
        logic signed [CW-1:0] unit_z;
        logic                 was_scaled;
    } t_out_item;

    // front end result: raw components, magnitudes, sum of squares
    typedef struct packed {
        t_vec            comps;
        t_vec            mags;
        logic [SUMW-1:0] sum;
    } t_fr;

    typedef struct packed {
        t_vec            comps;
        t_vec            mags;
        logic [SUMW-1:0] sum;
        logic [REMW-1:0] rem;
        logic [RTW-1:0]  root;
    } t_sqs;

    typedef struct packed {
        t_vec           comps;
        t_vec           mags;
        logic [RTW-1:0] root;
    } t_sq;

    typedef struct packed {
        t_vec                        comps;
        t_vec                        mags;
        logic [RTW-1:0]              div;
        logic                        scaled;
        logic [NCOMP-1:0][DRW-1:0]   rem;
        logic [NCOMP-1:0][QW-1:0]    quo;
    } t_dvs;

endpackage

/* rtl/quaternion_normalize_top.sv */
`timescale 1ns / 1ps

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------
// input     | in        | i_valid / o_stall  | i_data  (t_in_item)
// result    | out       | o_valid / i_stall  | o_data  (t_out_item)
// config    | in        | apb psel / penable | min_magnitude at byte 0
//
// one item enters per cycle unless a held result backs up to the input; the
// pipeline is the front end, the square root (one root bit per stage) and
// the dividers (one quotient bit per stage, four lanes side by side)
// synchronous active-low reset empties the pipeline and clears min_magnitude
// a held result stalls only the stages that hold items; bubbles still close up

module quaternion_normalize_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input item channel
    input  logic                      i_valid,
    input  qn_pkg::t_in_item          i_data,
    output logic                      o_stall,
    // result item channel
    output logic                      o_valid,
    output qn_pkg::t_out_item         o_data,
    input  logic                      i_stall,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [qn_pkg::PAW-1:0]    paddr,
    input  logic [qn_pkg::DW-1:0]     pwdata,
    output logic [qn_pkg::DW-1:0]     prdata,
    output logic                      pready
);
    import qn_pkg::*;

    logic [MINW-1:0] r_min_mag;
    t_vec            in_vec;
    logic            fr_ready, fr_valid, sq_ready, sq_valid, dv_ready;
    t_fr             fr_data;
    t_sq             sq_data;
    logic            sel_min;

    // register file: one threshold register, word address in paddr[2]
    assign pready  = 1'b1;
    assign sel_min = (paddr[PAW-1:2] == REG_MIN_MAGNITUDE);
    assign prdata  = sel_min ? DW'(r_min_mag) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag <= '0;
        end else if (psel && penable && pwrite && pready && sel_min) begin
            r_min_mag <= pwdata[MINW-1:0];
        end
    end

    // component order inside the datapath: lane 3 is w, lane 0 is z
    assign in_vec = {i_data.comp_w, i_data.comp_x, i_data.comp_y, i_data.comp_z};

    // magnitudes, squares and the 66-bit sum of squares
    qn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_comps (in_vec),
        .o_ready (fr_ready),
        .o_valid (fr_valid),
        .o_data  (fr_data),
        .i_ready (sq_ready)
    );

    // floor square root, one result bit per stage
    qn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_data  (fr_data),
        .o_ready (sq_ready),
        .o_valid (sq_valid),
        .o_data  (sq_data),
        .i_ready (dv_ready)
    );

    // threshold test, four dividers and final sign / pass-through select
    qn_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_mag (r_min_mag),
        .i_valid   (sq_valid),
        .i_data    (sq_data),
        .o_ready   (dv_ready),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_ready   (!i_stall)
    );

    assign o_stall = !fr_ready;

endmodule

/* rtl/qn_front.sv */
`timescale 1ns / 1ps

module qn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  qn_pkg::t_vec    i_comps,
    output logic            o_ready,
    output logic            o_valid,
    output qn_pkg::t_fr     o_data,
    input  logic            i_ready
);
    import qn_pkg::*;

    logic [3:0]                r_v;
    logic [4:0]                rdy;
    t_vec                      r_c0, r_m0, r_c1, r_m1, r_c2, r_m2, r_c3, r_m3;
    logic [NCOMP-1:0][SQW-1:0] r_q1;
    logic [1:0][SUMW-2:0]      r_p2;
    logic [SUMW-1:0]           r_sum3;
    t_vec                      n_m0;

    assign rdy[4] = i_ready;
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_rdy
            assign rdy[g] = !r_v[g] || rdy[g+1];
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            n_m0[i] = i_comps[i][CW-1] ? (~i_comps[i] + 1'b1) : i_comps[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_c0 <= i_comps;
            r_m0 <= n_m0;
        end
        if (rdy[1]) begin
            r_c1 <= r_c0;
            r_m1 <= r_m0;
            for (int i = 0; i < NCOMP; i++) begin
                r_q1[i] <= SQW'(r_m0[i]) * SQW'(r_m0[i]);
            end
        end
        if (rdy[2]) begin
            r_c2    <= r_c1;
            r_m2    <= r_m1;
            r_p2[0] <= {1'b0, r_q1[0]} + {1'b0, r_q1[1]};
            r_p2[1] <= {1'b0, r_q1[2]} + {1'b0, r_q1[3]};
        end
        if (rdy[3]) begin
            r_c3   <= r_c2;
            r_m3   <= r_m2;
            r_sum3 <= {1'b0, r_p2[0]} + {1'b0, r_p2[1]};
        end
    end

    assign o_ready      = rdy[0];
    assign o_valid      = r_v[3];
    assign o_data.comps = r_c3;
    assign o_data.mags  = r_m3;
    assign o_data.sum   = r_sum3;

endmodule

/* rtl/qn_sqrt.sv */
`timescale 1ns / 1ps

module qn_sqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  qn_pkg::t_fr  i_data,
    output logic         o_ready,
    output logic         o_valid,
    output qn_pkg::t_sq  o_data,
    input  logic         i_ready
);
    import qn_pkg::*;

    logic [SQ_STAGES-1:0] r_v;
    t_sqs                 r_s [SQ_STAGES];
    logic [SQ_STAGES:0]   rdy;

    assign rdy[SQ_STAGES] = i_ready;

    genvar s;
    generate
        for (s = 0; s < SQ_STAGES; s++) begin : g_stage
            localparam int P = SQ_STAGES - 1 - s;
            t_sqs            prev;
            t_sqs            n_s;
            logic            pv;
            logic [REMW-1:0] acc;
            logic [REMW-1:0] trial;

            if (s == 0) begin : g_first
                assign pv         = i_valid;
                assign prev.comps = i_data.comps;
                assign prev.mags  = i_data.mags;
                assign prev.sum   = i_data.sum;
                assign prev.rem   = '0;
                assign prev.root  = '0;
            end else begin : g_next
                assign pv   = r_v[s-1];
                assign prev = r_s[s-1];
            end

            // one root bit per stage from the next pair of radicand bits
            always_comb begin
                acc   = {prev.rem[REMW-3:0], prev.sum[2*P+1 -: 2]};
                trial = REMW'({prev.root, 2'b01});
                n_s   = prev;
                if (acc >= trial) begin
                    n_s.rem  = acc - trial;
                    n_s.root = {prev.root[RTW-2:0], 1'b1};
                end else begin
                    n_s.rem  = acc;
                    n_s.root = {prev.root[RTW-2:0], 1'b0};
                end
            end

            assign rdy[s] = !r_v[s] || rdy[s+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (rdy[s]) begin
                    r_v[s] <= pv;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[s]) r_s[s] <= n_s;
            end
        end
    endgenerate

    assign o_ready      = rdy[0];
    assign o_valid      = r_v[SQ_STAGES-1];
    assign o_data.comps = r_s[SQ_STAGES-1].comps;
    assign o_data.mags  = r_s[SQ_STAGES-1].mags;
    assign o_data.root  = r_s[SQ_STAGES-1].root;

endmodule

/* rtl/qn_div.sv */
`timescale 1ns / 1ps

module qn_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [qn_pkg::MINW-1:0] i_min_mag,
    input  logic                    i_valid,
    input  qn_pkg::t_sq             i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output qn_pkg::t_out_item       o_data,
    input  logic                    i_ready
);
    import qn_pkg::*;

    logic [DIV_STAGES-1:0] r_v;
    t_dvs                  r_s [DIV_STAGES];
    logic [DIV_STAGES:0]   rdy;
    t_vec                  res;
    t_dvs                  last;

    assign rdy[DIV_STAGES] = i_ready;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            t_dvs           prev;
            t_dvs           n_s;
            logic           pv;
            logic [DRW-1:0] acc;

            if (s == 0) begin : g_first
                assign pv          = i_valid;
                assign prev.comps  = i_data.comps;
                assign prev.mags   = i_data.mags;
                assign prev.div    = i_data.root;
                assign prev.scaled = i_data.root > RTW'(i_min_mag);
                assign prev.rem    = '0;
                assign prev.quo    = '0;
            end else begin : g_next
                assign pv   = r_v[s-1];
                assign prev = r_s[s-1];
            end

            // restoring division, one quotient bit per stage and lane
            always_comb begin
                n_s = prev;
                for (int i = 0; i < NCOMP; i++) begin
                    if (s == 0) acc = DRW'(prev.mags[i]);
                    else        acc = {prev.rem[i][DRW-2:0], 1'b0};
                    if (acc >= DRW'(prev.div)) begin
                        n_s.rem[i] = acc - DRW'(prev.div);
                        n_s.quo[i] = {prev.quo[i][QW-2:0], 1'b1};
                    end else begin
                        n_s.rem[i] = acc;
                        n_s.quo[i] = {prev.quo[i][QW-2:0], 1'b0};
                    end
                end
            end

            assign rdy[s] = !r_v[s] || rdy[s+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (rdy[s]) begin
                    r_v[s] <= pv;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[s]) r_s[s] <= n_s;
            end
        end
    endgenerate

    assign last = r_s[DIV_STAGES-1];

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            if (!last.scaled)            res[i] = last.comps[i];
            else if (last.comps[i][CW-1]) res[i] = ~CW'(last.quo[i]) + 1'b1;
            else                          res[i] = CW'(last.quo[i]);
        end
    end

    assign o_ready           = rdy[0];
    assign o_valid           = r_v[DIV_STAGES-1];
    assign o_data.unit_w     = res[3];
    assign o_data.unit_x     = res[2];
    assign o_data.unit_y     = res[1];
    assign o_data.unit_z     = res[0];
    assign o_data.was_scaled = last.scaled;

endmodule

/* rtl/qn_checker.sv */
`timescale 1ns / 1ps

module qn_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_stall,
    input  logic                      o_valid,
    input  qn_pkg::t_out_item         o_data,
    input  logic                      i_stall
);
    import qn_pkg::*;

    localparam logic signed [CW-1:0] ONE  = CW'(1) <<< FRAC_BITS;
    localparam logic signed [CW-1:0] MONE = -ONE;

    // pipeline is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("held result changed");

    // a scaled component never leaves the unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.was_scaled |->
            o_data.unit_w <= ONE && o_data.unit_w >= MONE &&
            o_data.unit_x <= ONE && o_data.unit_x >= MONE &&
            o_data.unit_y <= ONE && o_data.unit_y >= MONE &&
            o_data.unit_z <= ONE && o_data.unit_z >= MONE)
        else $error("scaled component out of range");

    // with no result shown and no receiver stall, the input is never stalled
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !i_stall && $past(!o_valid) |-> !o_stall)
        else $error("input stalled with free stages");

endmodule

bind quaternion_normalize_top qn_checker u_chk (.*);

/* test/tb_quaternion_normalize_top.sv */
`timescale 1ns / 1ps

// scoreboard: predicts the normalised quaternion for each accepted item and
// checks results in order
class qn_scoreboard;
    qn_pkg::t_out_item pending[$];
    logic [15:0]       min_mag;
    int                errors;

    function new();
        min_mag = '0;
        errors  = 0;
    endfunction

    // floor square root of a 65-bit sum of squares
    function automatic logic [32:0] floor_sqrt(logic [64:0] num);
        logic [66:0] rem;
        logic [66:0] res;
        logic [66:0] bitv;
        rem  = {2'b0, num};
        res  = '0;
        bitv = 67'd1 << 64;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[32:0];
    endfunction

    function automatic void note_input(qn_pkg::t_in_item it);
        logic [31:0]       comp [4];
        logic [32:0]       mag  [4];
        logic [64:0]       sum;
        logic [32:0]       root;
        logic [48:0]       quo;
        logic [31:0]       outv [4];
        qn_pkg::t_out_item exp;
        comp[0] = it.comp_w;
        comp[1] = it.comp_x;
        comp[2] = it.comp_y;
        comp[3] = it.comp_z;
        sum = '0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = comp[i][31] ? (33'h1_0000_0000 - {1'b0, comp[i]}) : {1'b0, comp[i]};
            sum = sum + 65'(mag[i]) * 65'(mag[i]);
        end
        root = floor_sqrt(sum);
        exp.was_scaled = (root > {17'b0, min_mag});
        for (int i = 0; i < 4; i++) begin
            if (exp.was_scaled) begin
                quo = ({16'b0, mag[i]} << qn_pkg::FRAC_BITS) / {16'b0, root};
                outv[i] = comp[i][31] ? (32'h0 - quo[31:0]) : quo[31:0];
            end else begin
                outv[i] = comp[i];
            end
        end
        exp.unit_w = outv[0];
        exp.unit_x = outv[1];
        exp.unit_y = outv[2];
        exp.unit_z = outv[3];
        pending.push_back(exp);
    endfunction

    function automatic void check_result(qn_pkg::t_out_item got);
        qn_pkg::t_out_item exp;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.unit_w !== exp.unit_w) begin
            $error("unit_w expected %h actual %h", exp.unit_w, got.unit_w);
            errors++;
        end
        if (got.unit_x !== exp.unit_x) begin
            $error("unit_x expected %h actual %h", exp.unit_x, got.unit_x);
            errors++;
        end
        if (got.unit_y !== exp.unit_y) begin
            $error("unit_y expected %h actual %h", exp.unit_y, got.unit_y);
            errors++;
        end
        if (got.unit_z !== exp.unit_z) begin
            $error("unit_z expected %h actual %h", exp.unit_z, got.unit_z);
            errors++;
        end
        if (got.was_scaled !== exp.was_scaled) begin
            $error("was_scaled expected %b actual %b", exp.was_scaled, got.was_scaled);
            errors++;
        end
    endfunction
endclass

module tb_quaternion_normalize_top;
    import qn_pkg::*;

    // pipeline depth in stages; drain_pipe adds a margin on top
    localparam int LATENCY = 54;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    t_in_item          i_data = '0;
    logic              o_stall;
    logic              o_valid;
    t_out_item         o_data;
    logic              i_stall = 1'b1;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PAW-1:0]    paddr = '0;
    logic [DW-1:0]     pwdata = '0;
    logic [DW-1:0]     prdata;
    logic              pready;

    qn_scoreboard      quat_board;
    // long receiver hold-off requested by the stimulus, counted in cycles
    int                hold_off_cycles = 0;

    quaternion_normalize_top dut (.*);

    always #5 i_clk = ~i_clk;

    // accepted items are noted and results checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) quat_board.note_input(i_data);
            if (o_valid && !i_stall) quat_board.check_result(o_data);
        end
    end

    // receiver: random stalls per result, with a long hold-off on request
    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            // stretches without stalls mixed with random waits
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall <= 1'b0;
            // keep ready until one result has been taken
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // register write over the apb port, setup then access phase
    task automatic write_min_magnitude(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAW'(REG_MIN_MAGNITUDE) << 2;
        pwdata  <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        quat_board.min_mag = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one item, after a random gap unless no_gap is set, and hold it until it is taken
    task automatic send_quat(input t_in_item it, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // wait until every expected result has come, then let the pipe drain
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (quat_board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return 32'($signed($urandom_range(0, 131072)) - 65536);  // within plus or minus one
            2: return 32'($signed($urandom_range(0, 64)) - 32);         // tiny
            3: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_quat();
        t_in_item it;
        it.comp_w = rand_comp();
        it.comp_x = rand_comp();
        it.comp_y = rand_comp();
        it.comp_z = rand_comp();
        return it;
    endfunction

    function automatic t_in_item make_quat(input logic [31:0] w, x, y, z);
        t_in_item it;
        it.comp_w = w;
        it.comp_x = x;
        it.comp_y = y;
        it.comp_z = z;
        return it;
    endfunction

    initial begin : stimulus
        logic [15:0] thresholds [5];
        quat_board = new();
        thresholds[0] = 16'd0;
        thresholds[1] = 16'hffff;
        thresholds[2] = 16'd1;
        thresholds[3] = 16'h0100;
        thresholds[4] = 16'h8000;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero quaternion, most negative everywhere, extremes,
        // unit quaternion, magnitudes just around the threshold
        write_min_magnitude(16'd0);
        send_quat(make_quat(32'h0, 32'h0, 32'h0, 32'h0), 1'b0);
        send_quat(make_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0);
        send_quat(make_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
        send_quat(make_quat(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff), 1'b0);
        send_quat(make_quat(32'h0001_0000, 32'h0, 32'h0, 32'h0), 1'b0);
        send_quat(make_quat(32'h0, 32'hffff_0000, 32'h0, 32'h0), 1'b0);
        send_quat(make_quat(32'h1, 32'h0, 32'h0, 32'h0), 1'b0);
        send_quat(make_quat(32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h1), 1'b0);
        send_quat(make_quat(32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hcccc_cccc), 1'b0);
        drain_pipe();
        write_min_magnitude(16'hffff);
        send_quat(make_quat(32'hffff, 32'h0, 32'h0, 32'h0), 1'b0);   // equal: passes
        send_quat(make_quat(32'h1_0000, 32'h0, 32'h0, 32'h0), 1'b0); // just above
        send_quat(make_quat(32'h8000, 32'h8000, 32'h8000, 32'h8000), 1'b0);
        send_quat(make_quat(32'h8000_0000, 32'h0, 32'h0, 32'h1), 1'b0);
        drain_pipe();

        // random phases at several thresholds
        for (int ph = 0; ph < 5; ph++) begin
            write_min_magnitude(thresholds[ph]);
            for (int n = 0; n < 80; n++) send_quat(rand_quat(), 1'b0);
            drain_pipe();
        end
        write_min_magnitude(16'($urandom()));
        // back-pressure: receiver holds off while items keep flowing
        hold_off_cycles = 150;
        for (int n = 0; n < 150; n++) send_quat(rand_quat(), 1'b1);
        drain_pipe();

        if (quat_board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
